// ===== src/mtf_pkg.sv =====
// shared constants, payload structs and control types for the move-to-front list
package mtf_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int VALUE_BITS = 16;
    localparam int TAG_BITS   = 8;

    localparam int IDX_W   = $clog2(LIST_DEPTH);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int ENTRY_W = VALUE_BITS + TAG_BITS;
    localparam int CMP_W   = CNT_W + 5;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_MOVE   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [1:0] STATUS_RANGE    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] item_value;
        logic [7:0]  item_tag;
        logic [4:0]  read_position;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_value;
        logic [7:0]  out_tag;
        logic [4:0]  out_position;
        logic [5:0]  entry_count;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ_WAIT,
        S_SEARCH,
        S_SHIFT,
        S_FRONT,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_APPEND,
        DP_FULL,
        DP_READ_ISSUE,
        DP_READ_TAKE,
        DP_RANGE,
        DP_IGNORE,
        DP_SEARCH_START,
        DP_SEARCH_NEXT,
        DP_NOTFOUND,
        DP_FOUND_FRONT,
        DP_FOUND,
        DP_SHIFT,
        DP_FRONT,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       empty;
        logic       in_range;
        logic       match;
        logic       last;
        logic       idx_zero;
        logic       shift_last;
        logic       out_free;
    } t_dp_status;

endpackage

// ===== src/mtf_ram.sv =====
// generic single-write, single-read ram with registered read data
module mtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/mtf_ctrl.sv =====
// controller state machine sequencing append, move-to-front and read operations
module mtf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mtf_pkg::t_dp_status i_status,
    output mtf_pkg::t_dp_op     o_op
);

    import mtf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                case (i_status.kind)
                    KIND_APPEND: n_state = S_DONE;
                    KIND_READ:   n_state = i_status.in_range ? S_READ_WAIT : S_DONE;
                    KIND_MOVE:   n_state = i_status.empty ? S_DONE : S_SEARCH;
                    default:     n_state = S_DONE;
                endcase
            end
            S_READ_WAIT: n_state = S_DONE;
            S_SEARCH: begin
                if (i_status.match) begin
                    n_state = i_status.idx_zero ? S_DONE : S_SHIFT;
                end else if (i_status.last) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_status.shift_last) begin
                    n_state = S_FRONT;
                end
            end
            S_FRONT: n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = DP_LOAD;
                end
            end
            S_START: begin
                case (i_status.kind)
                    KIND_APPEND: o_op = i_status.full ? DP_FULL : DP_APPEND;
                    KIND_READ:   o_op = i_status.in_range ? DP_READ_ISSUE : DP_RANGE;
                    KIND_MOVE:   o_op = i_status.empty ? DP_NOTFOUND : DP_SEARCH_START;
                    default:     o_op = DP_IGNORE;
                endcase
            end
            S_READ_WAIT: o_op = DP_READ_TAKE;
            S_SEARCH: begin
                if (i_status.match) begin
                    o_op = i_status.idx_zero ? DP_FOUND_FRONT : DP_FOUND;
                end else if (i_status.last) begin
                    o_op = DP_NOTFOUND;
                end else begin
                    o_op = DP_SEARCH_NEXT;
                end
            end
            S_SHIFT: o_op = DP_SHIFT;
            S_FRONT: o_op = DP_FRONT;
            S_DONE: begin
                if (i_status.out_free) begin
                    o_op = DP_EMIT;
                end
            end
            default: o_op = DP_NOP;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/mtf_datapath.sv =====
// list storage, search and shift pointers, result and output registers
module mtf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtf_pkg::t_dp_op     i_op,
    input  mtf_pkg::t_item      i_item,
    input  logic                i_out_ready,
    output mtf_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output mtf_pkg::t_result    o_result
);

    import mtf_pkg::*;

    logic [1:0]            r_kind;
    logic [VALUE_BITS-1:0] r_value;
    logic [TAG_BITS-1:0]   r_tag;
    logic [4:0]            r_rpos;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    logic [ENTRY_W-1:0]    r_mv;
    logic [1:0]            r_res_status;
    logic [15:0]           r_res_value;
    logic [7:0]            r_res_tag;
    logic [4:0]            r_res_pos;
    logic                  r_out_valid;
    t_result               r_out;

    logic [1:0]            n_kind;
    logic [VALUE_BITS-1:0] n_value;
    logic [TAG_BITS-1:0]   n_tag;
    logic [4:0]            n_rpos;
    logic [CNT_W-1:0]      n_count;
    logic [IDX_W-1:0]      n_idx;
    logic [ENTRY_W-1:0]    n_mv;
    logic [1:0]            n_res_status;
    logic [15:0]           n_res_value;
    logic [7:0]            n_res_tag;
    logic [4:0]            n_res_pos;
    logic                  n_out_valid;
    t_result               n_out;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic [VALUE_BITS-1:0] rd_value;
    logic [TAG_BITS-1:0]   rd_tag;
    logic                  full;
    logic                  out_free;

    mtf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_value = rd_data[ENTRY_W-1:TAG_BITS];
    assign rd_tag   = rd_data[TAG_BITS-1:0];
    assign full     = (r_count == CNT_W'(LIST_DEPTH));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.kind       = r_kind;
        o_status.full       = full;
        o_status.empty      = (r_count == '0);
        o_status.in_range   = (CMP_W'(r_rpos) < CMP_W'(r_count));
        o_status.match      = (rd_tag == r_tag);
        o_status.last       = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
        o_status.idx_zero   = (r_idx == '0);
        o_status.shift_last = (r_idx == IDX_W'(1));
        o_status.out_free   = out_free;
    end

    always_comb begin
        n_kind       = r_kind;
        n_value      = r_value;
        n_tag        = r_tag;
        n_rpos       = r_rpos;
        n_count      = r_count;
        n_idx        = r_idx;
        n_mv         = r_mv;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_tag    = r_res_tag;
        n_res_pos    = r_res_pos;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = {r_value, r_tag};
        rd_en        = 1'b0;
        rd_addr      = '0;
        case (i_op)
            DP_LOAD: begin
                n_kind  = i_item.kind;
                n_value = VALUE_BITS'(i_item.item_value);
                n_tag   = TAG_BITS'(i_item.item_tag);
                n_rpos  = i_item.read_position;
            end
            DP_APPEND: begin
                wr_en        = 1'b1;
                wr_addr      = IDX_W'(r_count);
                n_count      = r_count + CNT_W'(1);
                n_res_status = STATUS_OK;
                n_res_value  = '0;
                n_res_tag    = '0;
                n_res_pos    = '0;
            end
            DP_FULL: begin
                n_res_status = STATUS_FULL;
                n_res_value  = '0;
                n_res_tag    = '0;
                n_res_pos    = '0;
            end
            DP_READ_ISSUE: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(r_rpos);
            end
            DP_READ_TAKE: begin
                n_res_status = STATUS_OK;
                n_res_value  = 16'(rd_value);
                n_res_tag    = 8'(rd_tag);
                n_res_pos    = r_rpos;
            end
            DP_RANGE: begin
                n_res_status = STATUS_RANGE;
                n_res_value  = '0;
                n_res_tag    = '0;
                n_res_pos    = r_rpos;
            end
            DP_IGNORE: begin
                n_res_status = STATUS_OK;
                n_res_value  = '0;
                n_res_tag    = '0;
                n_res_pos    = '0;
            end
            DP_SEARCH_START: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_idx   = '0;
            end
            DP_SEARCH_NEXT: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + IDX_W'(1);
                n_idx   = r_idx + IDX_W'(1);
            end
            DP_NOTFOUND: begin
                n_res_status = STATUS_NOTFOUND;
                n_res_value  = '0;
                n_res_tag    = '0;
                n_res_pos    = '0;
            end
            DP_FOUND_FRONT: begin
                n_res_status = STATUS_OK;
                n_res_value  = 16'(rd_value);
                n_res_tag    = 8'(rd_tag);
                n_res_pos    = '0;
            end
            DP_FOUND: begin
                n_mv         = rd_data;
                n_res_status = STATUS_OK;
                n_res_value  = 16'(rd_value);
                n_res_tag    = 8'(rd_tag);
                n_res_pos    = 5'(r_idx);
                rd_en        = 1'b1;
                rd_addr      = r_idx - IDX_W'(1);
            end
            DP_SHIFT: begin
                // entry ahead moves back one place
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = rd_data;
                rd_en   = (r_idx != IDX_W'(1));
                rd_addr = r_idx - IDX_W'(2);
                n_idx   = r_idx - IDX_W'(1);
            end
            DP_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_mv;
            end
            DP_EMIT: begin
                n_out.status       = r_res_status;
                n_out.out_value    = r_res_value;
                n_out.out_tag      = r_res_tag;
                n_out.out_position = r_res_pos;
                n_out.entry_count  = 6'(r_count);
                n_out_valid        = 1'b1;
            end
            default: begin
                n_kind = r_kind;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_kind       <= n_kind;
        r_value      <= n_value;
        r_tag        <= n_tag;
        r_rpos       <= n_rpos;
        r_idx        <= n_idx;
        r_mv         <= n_mv;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_tag    <= n_res_tag;
        r_res_pos    <= n_res_pos;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_APPEND) |-> !full)
        else $error("append issued on a full list");

    a_shift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_SHIFT) |-> (r_idx != '0))
        else $error("shift at front position");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_EMIT) |=> r_out_valid)
        else $error("emitted result not presented");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_EMIT) |-> out_free)
        else $error("result overwrote a pending transfer");

endmodule

// ===== src/move_to_front_list.sv =====
// Move-to-front list of up to 32 value/tag entries held in one single-port-write,
// single-port-read RAM, one item at a time. An append or an unused kind goes
// straight to its result; an in-range read issues one RAM read and takes its data;
// a move of the entry found at position p runs a tag search from position 0 to p,
// shifts the entries ahead of it back one place and writes it to the front, with no
// shift and no front write when p is 0; a move whose tag is absent finds no match.
// The RAM does one read and one write per cycle. A finished result is held back
// while an earlier result still waits unaccepted in the output register. A new
// item is taken once the previous one has finished, even while its result still
// waits in the output register. No clearing pass after reset: the list is empty
// and only filled entries are read.
module move_to_front_list (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mtf_pkg::t_item   i_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mtf_pkg::t_result o_result
);

    import mtf_pkg::*;

    t_dp_op     dp_op;
    t_dp_status dp_status;

    mtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_op       (dp_op)
    );

    mtf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dp_op),
        .i_item      (i_item),
        .i_out_ready (i_out_ready),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_result    (o_result)
    );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for move_to_front_list: directed table then random list operations
module testbench;
    import mtf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1530;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        t_item   item;
        logic    fixed;
        t_result want;
    } t_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_ready;
    t_item   i_item = '0;
    logic    o_out_valid;
    logic    i_out_ready = 1'b0;
    t_result o_result;

    logic [VALUE_BITS-1:0] list_value [LIST_DEPTH];
    logic [TAG_BITS-1:0]   list_tag [LIST_DEPTH];
    int                    list_len = 0;

    t_result answer_q [$];
    logic    fixed_check = 1'b0;
    t_result fixed_result = '0;
    int      sent = 0;
    int      send_idle = 21;
    int      recv_idle = 86;
    int      error_count = 0;
    int      stall_cycles = 0;

    t_row plan [0:19] = '{
        '{'{KIND_READ,    16'h0000, 8'h00, 5'd0},  1'b1,
          '{STATUS_RANGE,    16'h0000, 8'h00, 5'd0,  6'd0}},
        '{'{KIND_MOVE,    16'h0000, 8'hFF, 5'd0},  1'b1,
          '{STATUS_NOTFOUND, 16'h0000, 8'h00, 5'd0,  6'd0}},
        '{'{KIND_UNUSED,  16'hFFFF, 8'hFF, 5'd31}, 1'b1,
          '{STATUS_OK,       16'h0000, 8'h00, 5'd0,  6'd0}},
        '{'{KIND_APPEND,  16'hFFFF, 8'hFF, 5'd31}, 1'b1,
          '{STATUS_OK,       16'h0000, 8'h00, 5'd0,  6'd1}},
        '{'{KIND_APPEND,  16'h0000, 8'h00, 5'd0},  1'b1,
          '{STATUS_OK,       16'h0000, 8'h00, 5'd0,  6'd2}},
        '{'{KIND_APPEND,  16'h1234, 8'h55, 5'd0},  1'b1,
          '{STATUS_OK,       16'h0000, 8'h00, 5'd0,  6'd3}},
        '{'{KIND_APPEND,  16'hABCD, 8'h55, 5'd0},  1'b1,
          '{STATUS_OK,       16'h0000, 8'h00, 5'd0,  6'd4}},
        '{'{KIND_READ,    16'h0000, 8'h00, 5'd0},  1'b1,
          '{STATUS_OK,       16'hFFFF, 8'hFF, 5'd0,  6'd4}},
        '{'{KIND_READ,    16'h0000, 8'h00, 5'd31}, 1'b1,
          '{STATUS_RANGE,    16'h0000, 8'h00, 5'd31, 6'd4}},
        '{'{KIND_READ,    16'h0000, 8'h00, 5'd4},  1'b1,
          '{STATUS_RANGE,    16'h0000, 8'h00, 5'd4,  6'd4}},
        '{'{KIND_MOVE,    16'h0000, 8'hFF, 5'd0},  1'b1,
          '{STATUS_OK,       16'hFFFF, 8'hFF, 5'd0,  6'd4}},
        '{'{KIND_MOVE,    16'h0000, 8'h55, 5'd0},  1'b1,
          '{STATUS_OK,       16'h1234, 8'h55, 5'd2,  6'd4}},
        '{'{KIND_MOVE,    16'hFFFF, 8'h55, 5'd31}, 1'b0, '0},
        '{'{KIND_MOVE,    16'h0000, 8'h00, 5'd0},  1'b0, '0},
        '{'{KIND_READ,    16'h0000, 8'h00, 5'd3},  1'b0, '0},
        '{'{KIND_MOVE,    16'h0000, 8'hAA, 5'd0},  1'b1,
          '{STATUS_NOTFOUND, 16'h0000, 8'h00, 5'd0,  6'd4}},
        '{'{KIND_APPEND,  16'h5A5A, 8'hA5, 5'd0},  1'b1,
          '{STATUS_OK,       16'h0000, 8'h00, 5'd0,  6'd5}},
        '{'{KIND_MOVE,    16'h0000, 8'hA5, 5'd0},  1'b0, '0},
        '{'{KIND_UNUSED,  16'h0000, 8'h00, 5'd0},  1'b1,
          '{STATUS_OK,       16'h0000, 8'h00, 5'd0,  6'd5}},
        '{'{KIND_READ,    16'h0000, 8'h00, 5'd1},  1'b0, '0}
    };

    move_to_front_list u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result apply_list_op(input t_item it);
        t_result               res;
        int                    hit;
        int                    p;
        logic [VALUE_BITS-1:0] mv;
        logic [TAG_BITS-1:0]   mt;
        res = '0;
        case (it.kind)
            KIND_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    list_value[list_len] = it.item_value;
                    list_tag[list_len] = it.item_tag;
                    list_len++;
                end
            end
            KIND_MOVE: begin
                hit = -1;
                for (p = list_len - 1; p >= 0; p--) begin
                    if (list_tag[p] == it.item_tag) hit = p;
                end
                if (hit < 0) begin
                    res.status = STATUS_NOTFOUND;
                end else begin
                    mv = list_value[hit];
                    mt = list_tag[hit];
                    for (p = hit; p > 0; p--) begin
                        list_value[p] = list_value[p-1];
                        list_tag[p] = list_tag[p-1];
                    end
                    list_value[0] = mv;
                    list_tag[0] = mt;
                    res.out_value = mv;
                    res.out_tag = mt;
                    res.out_position = hit[4:0];
                end
            end
            KIND_READ: begin
                res.out_position = it.read_position;
                if (int'(it.read_position) < list_len) begin
                    res.out_value = list_value[it.read_position];
                    res.out_tag = list_tag[it.read_position];
                end else begin
                    res.status = STATUS_RANGE;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = list_len[5:0];
        return res;
    endfunction

    // mostly tags and positions that exist in the list, the rest arbitrary
    function automatic t_item random_list_op();
        t_item it;
        int    roll;
        it.item_value = 16'($urandom);
        it.item_tag = 8'($urandom);
        it.read_position = 5'($urandom);
        roll = $urandom_range(99);
        if (roll < 12) begin
            it.kind = KIND_APPEND;
            if ($urandom_range(1) == 0) it.item_tag = 8'($urandom_range(7));
        end else if (roll < 60) begin
            it.kind = KIND_MOVE;
            if (list_len > 0 && $urandom_range(9) < 8) begin
                it.item_tag = list_tag[$urandom_range(list_len - 1)];
            end
        end else if (roll < 95) begin
            it.kind = KIND_READ;
            if (list_len > 0 && $urandom_range(9) < 8) begin
                it.read_position = 5'($urandom_range(list_len - 1));
            end
        end else begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(input t_item it, input logic fixed, input t_result want);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_item <= it;
        fixed_check = fixed;
        fixed_result = want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic set_idle_phase();
        if (sent < 520) begin
            send_idle = 21;
            recv_idle = 86;
        end else if (sent < 1040) begin
            send_idle = 86;
            recv_idle = 21;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = apply_list_op(i_item);
                if (fixed_check) want = fixed_result;
                answer_q.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got = o_result;
                if (answer_q.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    error_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.out_value !== want.out_value) begin
                        $error("out_value expected %0h got %0h", want.out_value, got.out_value);
                        error_count++;
                    end
                    if (got.out_tag !== want.out_tag) begin
                        $error("out_tag expected %0h got %0h", want.out_tag, got.out_tag);
                        error_count++;
                    end
                    if (got.out_position !== want.out_position) begin
                        $error("out_position expected %0d got %0d",
                               want.out_position, got.out_position);
                        error_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count expected %0d got %0d",
                               want.entry_count, got.entry_count);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("move_to_front_list verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int i;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (i = 0; i < $size(plan); i++) begin
            set_idle_phase();
            send_item(plan[i].item, plan[i].fixed, plan[i].want);
        end
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            set_idle_phase();
            send_item(random_list_op(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("move_to_front_list verification clean");
        end else begin
            $display("move_to_front_list verification failed");
        end
        $finish;
    end

endmodule

// ===== move_to_front_list.f =====
src/mtf_pkg.sv
src/mtf_ram.sv
src/mtf_ctrl.sv
src/mtf_datapath.sv
src/move_to_front_list.sv
test/testbench.sv
